>>> rtl/cvfc_pkg.sv
`default_nettype none

package cvfc_pkg;

  localparam int CELL_COUNT_DEF  = 8;
  localparam int FRAME_BYTES     = 16;
  localparam int POS_W           = $clog2(FRAME_BYTES);

  localparam logic [7:0] CRC_SEED = 8'h41;
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Code offset of 512, scaled by 3 into half-millivolt units.
  localparam logic [14:0] HALFMV_OFFSET = 15'd1536;

  localparam logic [7:0] FAULT_LIMIT_RST = 8'd5;
  localparam logic [7:0] FAULT_MAX       = 8'hFF;

  typedef logic [7:0]  byte_t;
  typedef logic [11:0] code_t;

endpackage

`default_nettype wire

>>> rtl/cvfc_ram.sv
`default_nettype none

module cvfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 12
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/cvfc_crc_nib.sv
`default_nettype none

module cvfc_crc_nib (
  input  wire logic [7:0] crc_in,
  output      logic [7:0] crc_out
);

  import cvfc_pkg::*;

  // Four bits of the MSB-first CRC-8 shift per pass.
  always_comb begin
    logic [7:0] c;
    c = crc_in;
    for (int i = 0; i < 4; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

>>> rtl/cell_voltage_frame_checker.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_rx_byte
// out_      output     out_valid / out_stall  cell index, code, halfmv, status
// cfg_      input      cfg_wr_en              cfg_wr_data (fault limit)
//
// A byte visits S_IDLE then S_CRC: the CRC unit folds in one nibble per cycle.
// After the 16th byte each cell result goes through two reads of the
// single-port frame store (S_RD_A, S_RD_B), an unpack state (S_CODE) and
// an output state (S_OUT), where out_stall can hold the result.
// rst_n is synchronous; the frame store itself is not cleared.
// in_stall is high whenever a byte or a frame is being worked on.

module cell_voltage_frame_checker #(
  parameter int CELL_COUNT = cvfc_pkg::CELL_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [7:0]         cfg_wr_data,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire cvfc_pkg::byte_t    in_rx_byte,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [2:0]         out_cell_index,
  output      cvfc_pkg::code_t    out_cell_code,
  output      logic signed [14:0] out_cell_halfmv,
  output      logic               out_pec_ok,
  output      logic [7:0]         out_fault_count,
  output      logic               out_comm_alarm,
  output      logic               out_last_cell
);

  import cvfc_pkg::*;

  localparam int STORE_BYTES = (CELL_COUNT * 3 + 1) / 2;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int CW          = $clog2(CELL_COUNT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CRC  = 3'd1;
  localparam logic [2:0] S_RD_A = 3'd2;
  localparam logic [2:0] S_RD_B = 3'd3;
  localparam logic [2:0] S_CODE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [7:0]       fault_r, fault_nxt;
  logic [7:0]       limit_r, limit_nxt;
  logic             pec_r, pec_nxt;
  logic [CW-1:0]    cell_r, cell_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  byte_t            byte_a_r;
  logic             out_valid_r, out_valid_nxt;

  logic [2:0]        out_idx_r;
  code_t             out_code_r;
  logic [14:0]       out_halfmv_r;
  logic              out_pec_r;
  logic [7:0]        out_fault_r;
  logic              out_alarm_r;
  logic              out_last_r;

  logic        in_acc, out_acc;
  logic        last_byte;
  logic [7:0]  crc_unit_in, crc_unit_out;
  logic        ram_we;
  logic [AW-1:0] ram_addr, addr_a, addr_b;
  byte_t       ram_rdata;
  code_t       code;
  logic [14:0] code_ext;
  logic        last_cell;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign last_byte = (pos_r == POS_W'(FRAME_BYTES - 1));
  assign last_cell = (cell_r == CW'(CELL_COUNT - 1));

  // The first nibble is folded in on the accept cycle, the second one after.
  assign crc_unit_in = (state_r == S_IDLE) ? (crc_r ^ in_rx_byte) : crc_r;

  cvfc_crc_nib u_crc (
    .crc_in  (crc_unit_in),
    .crc_out (crc_unit_out)
  );

  // Even cells start at the pair base, odd cells one byte later.
  assign addr_a = base_r + AW'(cell_r[0]);
  assign addr_b = addr_a + AW'(1);

  assign ram_we = in_acc && (pos_r < POS_W'(STORE_BYTES));

  always_comb begin
    case (state_r)
      S_RD_A:  ram_addr = addr_a;
      S_RD_B:  ram_addr = addr_b;
      default: ram_addr = pos_r[AW-1:0];
    endcase
  end

  cvfc_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .addr    (ram_addr),
    .wr_data (in_rx_byte),
    .rd_data (ram_rdata)
  );

  assign code = cell_r[0] ? {ram_rdata, byte_a_r[7:4]} : {ram_rdata[3:0], byte_a_r};
  assign code_ext = {3'd0, code};

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    fault_nxt     = fault_r;
    limit_nxt     = cfg_wr_en ? cfg_wr_data : limit_r;
    pec_nxt       = pec_r;
    cell_nxt      = cell_r;
    base_nxt      = base_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          crc_nxt   = crc_unit_out;
          state_nxt = S_CRC;
        end
      end
      S_CRC: begin
        if (last_byte) begin
          pec_nxt = (crc_unit_out == 8'd0);
          if (crc_unit_out == 8'd0) begin
            fault_nxt = 8'd0;
          end else if (fault_r != FAULT_MAX) begin
            fault_nxt = fault_r + 8'd1;
          end
          crc_nxt   = CRC_SEED;
          pos_nxt   = '0;
          cell_nxt  = '0;
          base_nxt  = '0;
          state_nxt = S_RD_A;
        end else begin
          crc_nxt   = crc_unit_out;
          pos_nxt   = pos_r + POS_W'(1);
          state_nxt = S_IDLE;
        end
      end
      S_RD_A: state_nxt = S_RD_B;
      S_RD_B: state_nxt = S_CODE;
      S_CODE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (last_cell) begin
            state_nxt = S_IDLE;
          end else begin
            cell_nxt  = cell_r + CW'(1);
            if (cell_r[0]) begin
              base_nxt = base_r + AW'(3);
            end
            state_nxt = S_RD_A;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      crc_r       <= CRC_SEED;
      fault_r     <= 8'd0;
      limit_r     <= FAULT_LIMIT_RST;
      pec_r       <= 1'b0;
      cell_r      <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      fault_r     <= fault_nxt;
      limit_r     <= limit_nxt;
      pec_r       <= pec_nxt;
      cell_r      <= cell_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD_B) begin
      byte_a_r <= ram_rdata;
    end
    if (state_r == S_CODE) begin
      out_idx_r    <= 3'(cell_r);
      out_code_r   <= code;
      // Times three by shift and add; the 15-bit wrap gives the signed result.
      out_halfmv_r <= (code_ext << 1) + code_ext - HALFMV_OFFSET;
      out_pec_r    <= pec_r;
      out_fault_r  <= fault_r;
      out_alarm_r  <= (fault_r >= limit_r);
      out_last_r   <= last_cell;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_index  = out_idx_r;
  assign out_cell_code   = out_code_r;
  assign out_cell_halfmv = $signed(out_halfmv_r);
  assign out_pec_ok      = out_pec_r;
  assign out_fault_count = out_fault_r;
  assign out_comm_alarm  = out_alarm_r;
  assign out_last_cell   = out_last_r;

  a_out_only_in_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OUT))
    else $error("result beat valid outside the output state");

  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && out_valid_r))
    else $error("byte accepted while a result is pending");

  a_crc_reseeded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CRC && last_byte) |=> (crc_r == CRC_SEED && pos_r == '0))
    else $error("CRC or byte position not restarted after frame end");

  a_last_cell_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_r) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after the last cell");

endmodule

`default_nettype wire
